// ===== rtl/fcfs_pkg.sv =====
// ----------------------------------------------------------------------------
// fcfs_pkg
// Shared widths, defaults and controller/datapath interface types for the
// first-come-first-served CPU owner arbiter.
// ----------------------------------------------------------------------------
package fcfs_pkg;

    localparam int QUEUE_DEPTH_DEF = 128;
    localparam int ID_BITS_DEF     = 22;
    localparam int REQ_ID_W        = 22;
    localparam int JOB_TIME_W      = 32;
    localparam int COUNT_OUT_W     = 8;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture the input item
        logic claim;       // idle CPU: requester becomes owner
        logic set_grant;   // owner continues
        logic go_idle;     // owner finished, queue empty
        logic pop_rd;      // read the queue head
        logic pop_commit;  // head becomes owner
        logic scan_start;  // begin duplicate scan
        logic scan_step;   // advance the duplicate scan
        logic push;        // append the requester ID
        logic set_ovf;     // queue full, ID dropped
        logic out_load;    // move result into the output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic owner_match; // idle, or requester is the owner
        logic tm_nz;       // job time is nonzero
        logic cnt_zero;    // queue empty
        logic full;        // queue full
        logic scan_done;   // scan finished
        logic scan_hit;    // requester already waiting
        logic out_busy;    // output register cannot take a new item
    } t_dp_sts;

endpackage

// ===== rtl/fcfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// fcfs_ctrl
// Sequencer for one request: decide, optional queue pop or duplicate scan,
// then hand the result to the output register.
// ----------------------------------------------------------------------------
module fcfs_ctrl
    import fcfs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_POP,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.claim = 1'b1;
                if (i_sts.owner_match) begin
                    if (i_sts.tm_nz) begin
                        o_cmd.set_grant = 1'b1;
                        n_state         = S_DONE;
                    end else if (i_sts.cnt_zero) begin
                        o_cmd.go_idle = 1'b1;
                        n_state       = S_DONE;
                    end else begin
                        o_cmd.pop_rd = 1'b1;
                        n_state      = S_POP;
                    end
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_POP: begin
                o_cmd.pop_commit = 1'b1;
                n_state          = S_DONE;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    if (!i_sts.scan_hit) begin
                        o_cmd.push    = !i_sts.full;
                        o_cmd.set_ovf = i_sts.full;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

// ===== rtl/fcfs_dp.sv =====
// ----------------------------------------------------------------------------
// fcfs_dp
// Owner registers, circular waiting queue in a memory with a registered read
// port, pipelined duplicate scan and the output register.
// ----------------------------------------------------------------------------
module fcfs_dp
    import fcfs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts,
    input  logic [REQ_ID_W-1:0]    i_requester_id,
    input  logic [JOB_TIME_W-1:0]  i_job_time,
    input  logic                   i_stall,
    output logic                   o_valid,
    output logic                   o_granted,
    output logic                   o_owner_valid,
    output logic [REQ_ID_W-1:0]    o_owner_id,
    output logic                   o_queue_overflow,
    output logic [COUNT_OUT_W-1:0] o_waiting_count_out
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    logic [ID_BITS-1:0] mem [QUEUE_DEPTH];

    logic [ID_BITS-1:0] w_req_id;
    logic [ID_BITS-1:0] r_in_id;
    logic               r_tm_nz;
    logic               r_owner_valid;
    logic [ID_BITS-1:0] r_owner_id;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   r_head;
    logic [PTR_W-1:0]   r_tail;
    logic [PTR_W-1:0]   r_scan_ptr;
    logic [CNT_W-1:0]   r_scan_idx;
    logic               r_cmp_vld;
    logic [ID_BITS-1:0] r_rd_data;
    logic               r_grant;
    logic               r_ovf;
    logic               r_out_vld;
    logic               w_rd_en;
    logic [PTR_W-1:0]   w_rd_addr;
    logic               w_scan_issue;
    logic               w_hit;
    logic [REQ_ID_W-1:0]    w_owner_out;
    logic [COUNT_OUT_W-1:0] w_count_out;

    // requester ID reduced or widened to ID_BITS
    if (ID_BITS >= REQ_ID_W) begin : g_id_wide
        assign w_req_id    = ID_BITS'(i_requester_id);
        assign w_owner_out = r_owner_id[REQ_ID_W-1:0];
    end else begin : g_id_narrow
        assign w_req_id    = i_requester_id[ID_BITS-1:0];
        assign w_owner_out = REQ_ID_W'(r_owner_id);
    end

    if (CNT_W >= COUNT_OUT_W) begin : g_cnt_wide
        assign w_count_out = r_count[COUNT_OUT_W-1:0];
    end else begin : g_cnt_narrow
        assign w_count_out = COUNT_OUT_W'(r_count);
    end

    assign w_scan_issue = i_cmd.scan_step && (r_scan_idx != r_count);
    assign w_rd_en      = i_cmd.pop_rd || w_scan_issue;
    assign w_rd_addr    = i_cmd.pop_rd ? r_head : r_scan_ptr;
    // compare of the entry read in the previous scan cycle
    assign w_hit        = r_cmp_vld && (r_rd_data == r_in_id);

    assign o_sts.owner_match = !r_owner_valid || (r_owner_id == r_in_id);
    assign o_sts.tm_nz       = r_tm_nz;
    assign o_sts.cnt_zero    = (r_count == '0);
    assign o_sts.full        = (r_count == CNT_FULL);
    assign o_sts.scan_done   = w_hit || (r_scan_idx == r_count);
    assign o_sts.scan_hit    = w_hit;
    assign o_sts.out_busy    = r_out_vld && i_stall;

    // queue memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[r_tail] <= r_in_id;
        end
        if (w_rd_en) begin
            r_rd_data <= mem[w_rd_addr];
        end
    end

    // payload captures
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in_id <= w_req_id;
            r_tm_nz <= |i_job_time;
        end
        if (i_cmd.scan_start) begin
            r_scan_ptr <= r_head;
        end else if (w_scan_issue) begin
            r_scan_ptr <= ptr_inc(r_scan_ptr);
        end
        if (i_cmd.out_load) begin
            o_granted           <= r_grant;
            o_owner_valid       <= r_owner_valid;
            o_owner_id          <= w_owner_out;
            o_queue_overflow    <= r_ovf;
            o_waiting_count_out <= w_count_out;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner_valid <= 1'b0;
            r_owner_id    <= '0;
            r_count       <= '0;
            r_head        <= '0;
            r_tail        <= '0;
            r_scan_idx    <= '0;
            r_cmp_vld     <= 1'b0;
            r_grant       <= 1'b0;
            r_ovf         <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            if (i_cmd.go_idle) begin
                r_owner_valid <= 1'b0;
                r_owner_id    <= '0;
            end else if (i_cmd.pop_commit) begin
                r_owner_valid <= 1'b1;
                r_owner_id    <= r_rd_data;
            end else if (i_cmd.claim && !r_owner_valid) begin
                r_owner_valid <= 1'b1;
                r_owner_id    <= r_in_id;
            end

            if (i_cmd.pop_commit) begin
                r_head  <= ptr_inc(r_head);
                r_count <= r_count - 1'b1;
            end else if (i_cmd.push) begin
                r_tail  <= ptr_inc(r_tail);
                r_count <= r_count + 1'b1;
            end

            if (i_cmd.scan_start) begin
                r_scan_idx <= '0;
                r_cmp_vld  <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_cmp_vld <= w_scan_issue;
                if (w_scan_issue) begin
                    r_scan_idx <= r_scan_idx + 1'b1;
                end
            end

            if (i_cmd.out_load) begin
                r_grant <= 1'b0;
                r_ovf   <= 1'b0;
            end else begin
                if (i_cmd.set_grant) begin
                    r_grant <= 1'b1;
                end
                if (i_cmd.set_ovf) begin
                    r_ovf <= 1'b1;
                end
            end

            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_vld;

endmodule

// ===== rtl/fcfs_cpu_owner_arbiter.sv =====
// ----------------------------------------------------------------------------
// An owner or idle request is decided at once; a handover to the queue head
// adds a registered read of the head; a non-owner request first runs the
// duplicate scan, which reads one queue entry per cycle.
// Throughput: one item at a time; the next item is taken while a result waits.
// Reset (synchronous, active low): CPU idle, owner 0, queue empty.
// ----------------------------------------------------------------------------
// fcfs_cpu_owner_arbiter
// First-come-first-served owner arbiter for a single CPU with a waiting queue.
// ----------------------------------------------------------------------------
module fcfs_cpu_owner_arbiter
    import fcfs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [REQ_ID_W-1:0]    i_requester_id,
    input  logic [JOB_TIME_W-1:0]  i_job_time,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_granted,
    output logic                   o_owner_valid,
    output logic [REQ_ID_W-1:0]    o_owner_id,
    output logic                   o_queue_overflow,
    output logic [COUNT_OUT_W-1:0] o_waiting_count_out
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    fcfs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    fcfs_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_requester_id      (i_requester_id),
        .i_job_time          (i_job_time),
        .i_stall             (i_stall),
        .o_valid             (o_valid),
        .o_granted           (o_granted),
        .o_owner_valid       (o_owner_valid),
        .o_owner_id          (o_owner_id),
        .o_queue_overflow    (o_queue_overflow),
        .o_waiting_count_out (o_waiting_count_out)
    );

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the FCFS CPU owner arbiter. A short table of
// directed requests covers idle claims, owner finish and handover, duplicates
// and extreme values. Random phases follow to fill the waiting queue past
// overflow and drain it again. Every result is checked against its table row
// or a local model of owner and queue, while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module testbench
    import fcfs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                   granted;
        logic                   owner_valid;
        logic [REQ_ID_W-1:0]    owner_id;
        logic                   queue_overflow;
        logic [COUNT_OUT_W-1:0] waiting_count;
    } t_arb_result;

    typedef struct {
        logic [REQ_ID_W-1:0]   id;
        logic [JOB_TIME_W-1:0] tm;
        bit                    known;
        t_arb_result           res;
    } t_dir_row;

    localparam int NUM_DIR = 15;

    logic                   i_clk;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic [REQ_ID_W-1:0]    i_requester_id = '0;
    logic [JOB_TIME_W-1:0]  i_job_time = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic                   o_granted;
    logic                   o_owner_valid;
    logic [REQ_ID_W-1:0]    o_owner_id;
    logic                   o_queue_overflow;
    logic [COUNT_OUT_W-1:0] o_waiting_count_out;

    // model state
    bit                  cpu_busy;
    logic [REQ_ID_W-1:0] cpu_owner;
    logic [REQ_ID_W-1:0] waiting_q[$];

    t_arb_result         pending_results[$];
    int                  mismatches = 0;
    int                  hold_cycles = 0;
    bit                  calm = 1'b0;
    logic [REQ_ID_W-1:0] id_pool[8];
    t_dir_row            dir_rows[NUM_DIR];

    fcfs_cpu_owner_arbiter u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_requester_id      (i_requester_id),
        .i_job_time          (i_job_time),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_granted           (o_granted),
        .o_owner_valid       (o_owner_valid),
        .o_owner_id          (o_owner_id),
        .o_queue_overflow    (o_queue_overflow),
        .o_waiting_count_out (o_waiting_count_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("[fcfs_cpu_owner_arbiter] ERROR");
        $finish;
    end

    // owner / queue model, one call per accepted item
    function automatic t_arb_result arbitrate(logic [REQ_ID_W-1:0] id,
                                              logic [JOB_TIME_W-1:0] tm);
        t_arb_result r;
        bit          found;
        r = '0;
        found = 1'b0;
        if (!cpu_busy) begin
            cpu_busy = 1'b1;
            cpu_owner = id;
        end
        if (cpu_owner == id) begin
            if (tm != '0) begin
                r.granted = 1'b1;
            end else if (waiting_q.size() == 0) begin
                cpu_busy = 1'b0;
                cpu_owner = '0;
            end else begin
                cpu_owner = waiting_q.pop_front();
            end
        end else begin
            foreach (waiting_q[i]) begin
                if (waiting_q[i] == id) found = 1'b1;
            end
            if (!found) begin
                if (waiting_q.size() < QUEUE_DEPTH_DEF) waiting_q.push_back(id);
                else r.queue_overflow = 1'b1;
            end
        end
        r.owner_valid = cpu_busy;
        r.owner_id = cpu_owner;
        r.waiting_count = COUNT_OUT_W'(waiting_q.size());
        return r;
    endfunction

    // mostly short gaps, a few long ones, none while calm
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [REQ_ID_W-1:0] pick_id(int owner_pct, int dup_pct);
        int r;
        r = $urandom_range(0, 99);
        if (cpu_busy && r < owner_pct) return cpu_owner;
        if (waiting_q.size() != 0 && r < owner_pct + dup_pct)
            return waiting_q[$urandom_range(0, waiting_q.size() - 1)];
        if (r < owner_pct + dup_pct + 10) return id_pool[$urandom_range(0, 7)];
        return REQ_ID_W'($urandom);
    endfunction

    function automatic logic [JOB_TIME_W-1:0] pick_time(int zero_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < zero_pct) return '0;
        if (r < zero_pct + 10) begin
            case ($urandom_range(0, 3))
                0: return 32'hFFFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'h7FFF_FFFF;
                default: return 32'd1;
            endcase
        end
        return $urandom;
    endfunction

    task automatic send_req(input logic [REQ_ID_W-1:0] id,
                            input logic [JOB_TIME_W-1:0] tm);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_requester_id <= id;
        i_job_time <= tm;
        do @(posedge i_clk); while (o_stall);
    endtask

    // sender pause until every expected item has come back
    task automatic drain_all();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic run_phase(int n, int owner_pct, int dup_pct, int zero_pct);
        logic [REQ_ID_W-1:0]   id;
        logic [JOB_TIME_W-1:0] tm;
        for (int k = 0; k < n; k++) begin
            id = pick_id(owner_pct, dup_pct);
            tm = pick_time(zero_pct);
            send_req(id, tm);
            pending_results.push_back(arbitrate(id, tm));
        end
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        int n;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                n = hold_cycles;
                hold_cycles = 0;
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end else begin
                n = pick_gap();
                if (n > 0) begin
                    i_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
            end
            i_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_arb_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected item: owner_id %0h", o_owner_id);
                mismatches++;
            end else begin
                e = pending_results.pop_front();
                if (o_granted !== e.granted) begin
                    $error("granted: expected %0d, got %0d", e.granted, o_granted);
                    mismatches++;
                end
                if (o_owner_valid !== e.owner_valid) begin
                    $error("owner_valid: expected %0d, got %0d",
                           e.owner_valid, o_owner_valid);
                    mismatches++;
                end
                if (o_owner_id !== e.owner_id) begin
                    $error("owner_id: expected %0h, got %0h", e.owner_id, o_owner_id);
                    mismatches++;
                end
                if (o_queue_overflow !== e.queue_overflow) begin
                    $error("queue_overflow: expected %0d, got %0d",
                           e.queue_overflow, o_queue_overflow);
                    mismatches++;
                end
                if (o_waiting_count_out !== e.waiting_count) begin
                    $error("waiting_count_out: expected %0d, got %0d",
                           e.waiting_count, o_waiting_count_out);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        t_arb_result r;
        id_pool = '{22'h0, 22'h3FFFFF, 22'h1, 22'h2AAAAA, 22'h155555, 22'h200000,
                    22'h000123, 22'h3FFFFE};
        // idle claims, finish, duplicates, handover, extreme and zero times
        dir_rows = '{
            '{22'h000005, 32'd7,        1'b1, '{1'b1, 1'b1, 22'h000005, 1'b0, 8'd0}},
            '{22'h000005, 32'd0,        1'b1, '{1'b0, 1'b0, 22'h000000, 1'b0, 8'd0}},
            '{22'h3FFFFF, 32'd0,        1'b1, '{1'b0, 1'b0, 22'h000000, 1'b0, 8'd0}},
            '{22'h000000, 32'hFFFFFFFF, 1'b1, '{1'b1, 1'b1, 22'h000000, 1'b0, 8'd0}},
            '{22'h3FFFFF, 32'h7FFFFFFF, 1'b1, '{1'b0, 1'b1, 22'h000000, 1'b0, 8'd1}},
            '{22'h3FFFFF, 32'h80000000, 1'b1, '{1'b0, 1'b1, 22'h000000, 1'b0, 8'd1}},
            '{22'h2AAAAA, 32'd0,        1'b1, '{1'b0, 1'b1, 22'h000000, 1'b0, 8'd2}},
            '{22'h155555, 32'd1,        1'b0, '0},
            '{22'h000000, 32'd0,        1'b1, '{1'b0, 1'b1, 22'h3FFFFF, 1'b0, 8'd2}},
            '{22'h3FFFFF, 32'hFFFFFFFF, 1'b1, '{1'b1, 1'b1, 22'h3FFFFF, 1'b0, 8'd2}},
            '{22'h2AAAAA, 32'd5,        1'b0, '0},
            '{22'h3FFFFF, 32'd0,        1'b0, '0},
            '{22'h2AAAAA, 32'd0,        1'b0, '0},
            '{22'h155555, 32'd0,        1'b1, '{1'b0, 1'b0, 22'h000000, 1'b0, 8'd0}},
            '{22'h000000, 32'd0,        1'b1, '{1'b0, 1'b0, 22'h000000, 1'b0, 8'd0}}
        };
        cpu_busy = 1'b0;
        cpu_owner = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            send_req(dir_rows[i].id, dir_rows[i].tm);
            r = arbitrate(dir_rows[i].id, dir_rows[i].tm);
            pending_results.push_back(dir_rows[i].known ? dir_rows[i].res : r);
        end
        drain_all();

        run_phase(450, 35, 20, 30);
        drain_all();

        // fill the queue past full while the receiver holds off
        hold_cycles = 400;
        run_phase(300, 3, 10, 20);
        drain_all();

        run_phase(200, 70, 15, 80);

        calm = 1'b1;
        run_phase(200, 35, 20, 30);
        calm = 1'b0;
        run_phase(380, 35, 20, 30);

        drain_all();
        repeat (140) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[fcfs_cpu_owner_arbiter] OK");
        end else begin
            $display("[fcfs_cpu_owner_arbiter] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/fcfs_pkg.sv
rtl/fcfs_ctrl.sv
rtl/fcfs_dp.sv
rtl/fcfs_cpu_owner_arbiter.sv
bench/testbench.sv
